/* hw/rtl/lsps_pkg.sv */
// Shared types and constants for the line sensor steering block.
`timescale 1ns / 1ps

package lsps_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int SAMPLE_FIELDS = 8;
    localparam int PAT_W         = 8;
    localparam int SPEED_W       = 11;
    localparam int GAIN_W        = 8;
    localparam int SETP_W        = 4;
    localparam int CONF_W        = 4;
    localparam int MODE_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 11;

    // sum of 2*i over at most sixteen channels stays below 256
    localparam int SUM_W  = 8;
    localparam int CNT_W  = 5;
    localparam int ITER_W = $clog2(SUM_W);
    localparam int CORR_W = GAIN_W + SUM_W + 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam int THR_RESET = 2048;

    localparam logic [GAIN_W-1:0]  GAIN_RESET       = GAIN_W'(30);
    localparam logic [SETP_W-1:0]  SETPOINT_RESET   = SETP_W'(7);
    localparam logic [SPEED_W-1:0] BASE_SPEED_RESET = SPEED_W'(1000);
    localparam logic [SPEED_W-1:0] SPEED_LO_RESET   = SPEED_W'(400);
    localparam logic [SPEED_W-1:0] SPEED_HI_RESET   = SPEED_W'(1200);
    localparam logic [CONF_W-1:0]  CONFIRM_RESET    = CONF_W'(2);
    localparam logic [SPEED_W-1:0] TURN_FAST_RESET  = SPEED_W'(1200);
    localparam logic [SPEED_W-1:0] TURN_SLOW_RESET  = SPEED_W'(800);

    typedef enum logic [MODE_W-1:0] {
        MODE_RUN        = 3'd0,
        MODE_CAL_SAMPLE = 3'd1,
        MODE_CAL_FINISH = 3'd2,
        MODE_LOAD_THR   = 3'd3,
        MODE_OBSERVE    = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN          = 3'd0,
        CFG_SETPOINT      = 3'd1,
        CFG_BASE_SPEED    = 3'd2,
        CFG_SPEED_LO      = 3'd3,
        CFG_SPEED_HI      = 3'd4,
        CFG_CONFIRM_COUNT = 3'd5,
        CFG_TURN_FAST     = 3'd6,
        CFG_TURN_SLOW     = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PIVOT_LEFT,
        OP_PIVOT_RIGHT,
        OP_STEER,
        OP_STOP
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DIV,
        BS_MUL,
        BS_CLAMP,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [SETP_W-1:0]  setpoint;
        logic [SPEED_W-1:0] base_speed;
        logic [SPEED_W-1:0] speed_lo;
        logic [SPEED_W-1:0] speed_hi;
        logic [CONF_W-1:0]  confirm_count;
        logic [SPEED_W-1:0] turn_fast;
        logic [SPEED_W-1:0] turn_slow;
    } t_cfg;

    // one classified request handed from front to back
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        t_op              op;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

endpackage

/* hw/rtl/lsps_front.sv */
// Front end: threshold compare, pattern classification and calibration state.
`timescale 1ns / 1ps

module lsps_front #(
    parameter int CHANNELS   = 8,
    parameter int SAMPLE_MAX = 4095
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [lsps_pkg::MODE_W-1:0]   i_mode,
    input  logic [lsps_pkg::SAMPLE_W-1:0] i_smp [CHANNELS],
    input  lsps_pkg::t_cfg                i_cfg,
    output lsps_pkg::t_cmd                o_cmd
);

    localparam int SMP_BITS = $clog2(SAMPLE_MAX + 1);
    localparam int TW = (SMP_BITS > lsps_pkg::SAMPLE_W) ? SMP_BITS : lsps_pkg::SAMPLE_W;
    localparam logic [TW-1:0]       SMAX     = TW'(SAMPLE_MAX);
    localparam logic [TW-1:0]       THR_INIT = TW'(lsps_pkg::THR_RESET);
    localparam logic [CHANNELS-1:0] ALL_ONES = {CHANNELS{1'b1}};
    localparam logic [CHANNELS-1:0] LOW_BIT  = CHANNELS'(1);
    localparam logic [CHANNELS-1:0] TOP_BIT  = LOW_BIT << (CHANNELS - 1);

    logic [TW-1:0] r_thr    [CHANNELS];
    logic [TW-1:0] n_thr    [CHANNELS];
    logic [TW-1:0] r_cal_hi [CHANNELS];
    logic [TW-1:0] n_cal_hi [CHANNELS];
    logic [TW-1:0] r_cal_lo [CHANNELS];
    logic [TW-1:0] n_cal_lo [CHANNELS];
    logic [CHANNELS-1:0]         r_prev, n_prev;
    logic [lsps_pkg::CONF_W-1:0] r_conf_left, n_conf_left;

    logic [TW-1:0]        smp_x [CHANNELS];
    logic signed [TW:0]   diff  [CHANNELS];
    logic signed [TW:0]   half  [CHANNELS];
    logic [CHANNELS-1:0]  pat;
    logic [CHANNELS-1:0]  lowest;
    logic                 run_valid;
    logic [lsps_pkg::SUM_W-1:0] sum;
    logic [lsps_pkg::CNT_W-1:0] cnt;
    logic [lsps_pkg::PAT_W-1:0] pat_out;
    lsps_pkg::t_op              op;
    lsps_pkg::t_mode            mode;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            smp_x[i] = TW'(i_smp[i]);
            pat[CHANNELS-1-i] = smp_x[i] > r_thr[i];
        end
    end

    // one contiguous run: adding the lowest set bit clears the whole run
    assign lowest    = pat & (~pat + LOW_BIT);
    assign run_valid = (pat != '0) && (pat != ALL_ONES) && (pat == r_prev) &&
                       ((pat & (pat + lowest)) == '0);

    always_comb begin
        sum = '0;
        cnt = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (pat[i]) begin
                sum = sum + lsps_pkg::SUM_W'(2 * i);
                cnt = cnt + 1'b1;
            end
        end
    end

    // midpoint with the halving truncated toward zero
    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            diff[i] = $signed({1'b0, r_cal_hi[i]}) - $signed({1'b0, r_cal_lo[i]});
            half[i] = (diff[i] + $signed({{TW{1'b0}}, diff[i][TW]})) >>> 1;
        end
    end

    assign mode = lsps_pkg::t_mode'(i_mode);

    always_comb begin
        n_thr       = r_thr;
        n_cal_hi    = r_cal_hi;
        n_cal_lo    = r_cal_lo;
        n_prev      = r_prev;
        n_conf_left = r_conf_left;
        op          = lsps_pkg::OP_NONE;
        unique case (mode)
            lsps_pkg::MODE_RUN: begin
                if (run_valid) begin
                    if (r_conf_left == '0) begin
                        if (pat == LOW_BIT) begin
                            op = lsps_pkg::OP_PIVOT_LEFT;
                        end else if (pat == TOP_BIT) begin
                            op = lsps_pkg::OP_PIVOT_RIGHT;
                        end else begin
                            op = lsps_pkg::OP_STEER;
                        end
                        n_conf_left = i_cfg.confirm_count;
                    end else begin
                        n_conf_left = r_conf_left - 1'b1;
                    end
                end else begin
                    n_prev      = pat;
                    n_conf_left = i_cfg.confirm_count;
                end
            end
            lsps_pkg::MODE_CAL_SAMPLE: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (smp_x[i] > r_cal_hi[i]) n_cal_hi[i] = smp_x[i];
                    if (smp_x[i] < r_cal_lo[i]) n_cal_lo[i] = smp_x[i];
                end
            end
            lsps_pkg::MODE_CAL_FINISH: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_thr[i]    = r_cal_lo[i] + half[i][TW-1:0];
                    n_cal_hi[i] = '0;
                    n_cal_lo[i] = SMAX;
                end
                op = lsps_pkg::OP_STOP;
            end
            lsps_pkg::MODE_LOAD_THR: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_thr[i] = (smp_x[i] > SMAX) ? SMAX : smp_x[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_thr[i]    <= THR_INIT;
                r_cal_hi[i] <= '0;
                r_cal_lo[i] <= SMAX;
            end
            r_prev      <= '0;
            r_conf_left <= lsps_pkg::CONFIRM_RESET;
        end else if (i_push) begin
            r_thr       <= n_thr;
            r_cal_hi    <= n_cal_hi;
            r_cal_lo    <= n_cal_lo;
            r_prev      <= n_prev;
            r_conf_left <= n_conf_left;
        end
    end

    // reported pattern is the low byte; missing bits read as zero
    for (genvar b = 0; b < lsps_pkg::PAT_W; b++) begin : g_pat
        if (b < CHANNELS) begin : g_have
            assign pat_out[b] = pat[b];
        end else begin : g_none
            assign pat_out[b] = 1'b0;
        end
    end

    assign o_cmd.pattern = pat_out;
    assign o_cmd.op      = op;
    assign o_cmd.sum     = sum;
    assign o_cmd.cnt     = cnt;

endmodule

/* hw/rtl/lsps_queue.sv */
// Small request queue between the front end and the drive back end.
`timescale 1ns / 1ps

module lsps_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lsps_pkg::t_cmd i_data,
    input  logic           i_pop,
    output lsps_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);

    lsps_pkg::t_cmd                r_mem [lsps_pkg::Q_DEPTH];
    logic [lsps_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [lsps_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [lsps_pkg::Q_PTR_W:0]    r_count;

    assign o_full  = r_count == (lsps_pkg::Q_PTR_W + 1)'(lsps_pkg::Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/lsps_back.sv */
// Back end: centroid divide, gain multiply, clamp and drive value update.
`timescale 1ns / 1ps

module lsps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsps_pkg::t_cfg                i_cfg,
    input  logic                          i_q_empty,
    input  lsps_pkg::t_cmd                i_q_data,
    output logic                          o_q_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [lsps_pkg::PAT_W-1:0]    o_line_pattern,
    output logic                          o_drive_update,
    output logic [lsps_pkg::SPEED_W-1:0]  o_right_reverse,
    output logic [lsps_pkg::SPEED_W-1:0]  o_right_forward,
    output logic [lsps_pkg::SPEED_W-1:0]  o_left_reverse,
    output logic [lsps_pkg::SPEED_W-1:0]  o_left_forward
);

    localparam int SUM_W   = lsps_pkg::SUM_W;
    localparam int CNT_W   = lsps_pkg::CNT_W;
    localparam int CORR_W  = lsps_pkg::CORR_W;
    localparam int SPEED_W = lsps_pkg::SPEED_W;
    localparam int XW      = CORR_W + 1;

    lsps_pkg::t_bstate r_state, n_state;
    lsps_pkg::t_cmd    r_cmd;

    logic [CNT_W-1:0]            r_rem;
    logic [SUM_W-1:0]            r_dvd;
    logic [SUM_W-1:0]            r_quo;
    logic [lsps_pkg::ITER_W-1:0] r_iter;
    logic signed [CORR_W-1:0]    r_corr;
    logic [SPEED_W-1:0]          r_steer_rf, r_steer_lf;
    logic [SPEED_W-1:0]          r_rr, r_rf, r_lr, r_lf;
    logic                        r_out_valid;
    logic [lsps_pkg::PAT_W-1:0]  r_out_pat;
    logic                        r_out_upd;

    logic                        out_free;
    logic                        load_out;
    logic                        div_last;
    logic [CNT_W:0]              rem_sh;
    logic                        rem_ge;
    logic signed [SUM_W:0]       err;
    logic signed [CORR_W-1:0]    prod;
    logic signed [XW-1:0]        base_x, corr_x, rf_x, lf_x;

    function automatic logic [SPEED_W-1:0] clamp_speed(
        input logic signed [XW-1:0] x,
        input logic [SPEED_W-1:0]   lo,
        input logic [SPEED_W-1:0]   hi
    );
        logic [SPEED_W-1:0] res;
        if (x < $signed({{(XW - SPEED_W){1'b0}}, lo})) begin
            res = lo;
        end else if (x > $signed({{(XW - SPEED_W){1'b0}}, hi})) begin
            res = hi;
        end else begin
            res = x[SPEED_W-1:0];
        end
        return res;
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign div_last = r_iter == lsps_pkg::ITER_W'(SUM_W - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsps_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_q_data.op == lsps_pkg::OP_STEER) ? lsps_pkg::BS_DIV
                                                                  : lsps_pkg::BS_DONE;
                end
            end
            lsps_pkg::BS_DIV:   if (div_last) n_state = lsps_pkg::BS_MUL;
            lsps_pkg::BS_MUL:   n_state = lsps_pkg::BS_CLAMP;
            lsps_pkg::BS_CLAMP: n_state = lsps_pkg::BS_DONE;
            lsps_pkg::BS_DONE:  if (out_free) n_state = lsps_pkg::BS_IDLE;
            default:            n_state = lsps_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            lsps_pkg::BS_IDLE: o_q_pop  = !i_q_empty;
            lsps_pkg::BS_DONE: load_out = out_free;
            default: begin
            end
        endcase
    end

    // restoring divide, one quotient bit a cycle
    assign rem_sh = {r_rem, r_dvd[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_cmd.cnt};

    assign err  = $signed({1'b0, r_quo}) -
                  $signed({{(SUM_W + 1 - lsps_pkg::SETP_W){1'b0}}, i_cfg.setpoint});
    assign prod = $signed({1'b0, i_cfg.gain}) * err;

    assign base_x = $signed({{(XW - SPEED_W){1'b0}}, i_cfg.base_speed});
    assign corr_x = XW'(r_corr);
    assign rf_x   = base_x - corr_x;
    assign lf_x   = base_x + corr_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd  <= i_q_data;
            r_dvd  <= i_q_data.sum;
            r_rem  <= '0;
            r_quo  <= '0;
            r_iter <= '0;
        end
        if (r_state == lsps_pkg::BS_DIV) begin
            r_rem  <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_cmd.cnt}) : rem_sh[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
            r_dvd  <= r_dvd << 1;
            r_iter <= r_iter + 1'b1;
        end
        if (r_state == lsps_pkg::BS_MUL) begin
            r_corr <= prod;
        end
        if (r_state == lsps_pkg::BS_CLAMP) begin
            r_steer_rf <= clamp_speed(rf_x, i_cfg.speed_lo, i_cfg.speed_hi);
            r_steer_lf <= clamp_speed(lf_x, i_cfg.speed_lo, i_cfg.speed_hi);
        end
        if (load_out) begin
            r_out_pat <= r_cmd.pattern;
            r_out_upd <= r_cmd.op != lsps_pkg::OP_NONE;
        end
    end

    // drive values only move when a result is loaded, so they feed the ports directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rr        <= '0;
            r_rf        <= '0;
            r_lr        <= '0;
            r_lf        <= '0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
            case (r_cmd.op)
                lsps_pkg::OP_PIVOT_LEFT: begin
                    r_rr <= '0;
                    r_rf <= i_cfg.turn_fast;
                    r_lr <= i_cfg.turn_slow;
                    r_lf <= '0;
                end
                lsps_pkg::OP_PIVOT_RIGHT: begin
                    r_rr <= i_cfg.turn_slow;
                    r_rf <= '0;
                    r_lr <= '0;
                    r_lf <= i_cfg.turn_fast;
                end
                lsps_pkg::OP_STEER: begin
                    r_rr <= '0;
                    r_rf <= r_steer_rf;
                    r_lr <= '0;
                    r_lf <= r_steer_lf;
                end
                lsps_pkg::OP_STOP: begin
                    r_rr <= '0;
                    r_rf <= '0;
                    r_lr <= '0;
                    r_lf <= '0;
                end
                default: begin
                end
            endcase
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_pattern  = r_out_pat;
    assign o_drive_update  = r_out_upd;
    assign o_right_reverse = r_rr;
    assign o_right_forward = r_rf;
    assign o_left_reverse  = r_lr;
    assign o_left_forward  = r_lf;

endmodule

/* hw/rtl/line_sensor_p_steering.sv */
// Line sensor steering top level: config registers, front end, queue, back end.
// Flow: the queue holds each item; the back end pops it in idle, a steering item
// then runs a restoring divide, multiply and clamp, and done loads the result.
// Throughput: inputs enter at 1 per cycle until the 4-entry queue fills; the
// back end takes one item at a time and holds a result while the output stalls.
// Reset: synchronous, active low; queue entries and datapath regs are not cleared.
`timescale 1ns / 1ps

module line_sensor_p_steering #(
    parameter int CHANNELS   = 8,
    parameter int SAMPLE_MAX = 4095
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lsps_pkg::MODE_W-1:0]      i_mode,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_0,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_1,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_2,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_3,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_4,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_5,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_6,
    input  logic [lsps_pkg::SAMPLE_W-1:0]    i_sample_7,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lsps_pkg::PAT_W-1:0]       o_line_pattern,
    output logic                             o_drive_update,
    output logic [lsps_pkg::SPEED_W-1:0]     o_right_reverse,
    output logic [lsps_pkg::SPEED_W-1:0]     o_right_forward,
    output logic [lsps_pkg::SPEED_W-1:0]     o_left_reverse,
    output logic [lsps_pkg::SPEED_W-1:0]     o_left_forward,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    lsps_pkg::t_cfg r_cfg;
    lsps_pkg::t_cmd front_cmd;
    lsps_pkg::t_cmd q_data;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           push;

    logic [lsps_pkg::SAMPLE_W-1:0] fields [lsps_pkg::SAMPLE_FIELDS];
    logic [lsps_pkg::SAMPLE_W-1:0] smp    [CHANNELS];

    assign fields = '{i_sample_0, i_sample_1, i_sample_2, i_sample_3,
                      i_sample_4, i_sample_5, i_sample_6, i_sample_7};

    // channels beyond the sample fields read as zero
    for (genvar i = 0; i < CHANNELS; i++) begin : g_smp
        if (i < lsps_pkg::SAMPLE_FIELDS) begin : g_field
            assign smp[i] = fields[i];
        end else begin : g_zero
            assign smp[i] = '0;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain          <= lsps_pkg::GAIN_RESET;
            r_cfg.setpoint      <= lsps_pkg::SETPOINT_RESET;
            r_cfg.base_speed    <= lsps_pkg::BASE_SPEED_RESET;
            r_cfg.speed_lo      <= lsps_pkg::SPEED_LO_RESET;
            r_cfg.speed_hi      <= lsps_pkg::SPEED_HI_RESET;
            r_cfg.confirm_count <= lsps_pkg::CONFIRM_RESET;
            r_cfg.turn_fast     <= lsps_pkg::TURN_FAST_RESET;
            r_cfg.turn_slow     <= lsps_pkg::TURN_SLOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lsps_pkg::t_cfg_idx'(i_cfg_index))
                lsps_pkg::CFG_GAIN:
                    r_cfg.gain <= i_cfg_data[lsps_pkg::GAIN_W-1:0];
                lsps_pkg::CFG_SETPOINT:
                    r_cfg.setpoint <= i_cfg_data[lsps_pkg::SETP_W-1:0];
                lsps_pkg::CFG_BASE_SPEED:
                    r_cfg.base_speed <= i_cfg_data[lsps_pkg::SPEED_W-1:0];
                lsps_pkg::CFG_SPEED_LO:
                    r_cfg.speed_lo <= i_cfg_data[lsps_pkg::SPEED_W-1:0];
                lsps_pkg::CFG_SPEED_HI:
                    r_cfg.speed_hi <= i_cfg_data[lsps_pkg::SPEED_W-1:0];
                lsps_pkg::CFG_CONFIRM_COUNT:
                    r_cfg.confirm_count <= i_cfg_data[lsps_pkg::CONF_W-1:0];
                lsps_pkg::CFG_TURN_FAST:
                    r_cfg.turn_fast <= i_cfg_data[lsps_pkg::SPEED_W-1:0];
                lsps_pkg::CFG_TURN_SLOW:
                    r_cfg.turn_slow <= i_cfg_data[lsps_pkg::SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign push       = i_in_valid && !q_full;

    lsps_front #(
        .CHANNELS   (CHANNELS),
        .SAMPLE_MAX (SAMPLE_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_mode  (i_mode),
        .i_smp   (smp),
        .i_cfg   (r_cfg),
        .o_cmd   (front_cmd)
    );

    lsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lsps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (q_empty),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_line_pattern  (o_line_pattern),
        .o_drive_update  (o_drive_update),
        .o_right_reverse (o_right_reverse),
        .o_right_forward (o_right_forward),
        .o_left_reverse  (o_left_reverse),
        .o_left_forward  (o_left_forward)
    );

endmodule

/* hw/rtl/lsps_checker.sv */
// Port-level checks for the line sensor steering block, bound to the top level.
`timescale 1ns / 1ps

module lsps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [lsps_pkg::PAT_W-1:0]      o_line_pattern,
    input logic                            o_drive_update,
    input logic [lsps_pkg::SPEED_W-1:0]    o_right_reverse,
    input logic [lsps_pkg::SPEED_W-1:0]    o_right_forward,
    input logic [lsps_pkg::SPEED_W-1:0]    o_left_reverse,
    input logic [lsps_pkg::SPEED_W-1:0]    o_left_forward
);

    // a held result keeps its pattern, update flag and forward drive values
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_line_pattern) &&
            $stable(o_drive_update) && $stable(o_right_forward) &&
            $stable(o_left_forward))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

    // right reverse only comes from a right pivot
    a_pivot_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_right_reverse != '0 |->
            o_right_forward == '0 && o_left_reverse == '0)
        else $error("right reverse with conflicting drive values");

    a_pivot_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_left_reverse != '0 |->
            o_left_forward == '0 && o_right_reverse == '0)
        else $error("left reverse with conflicting drive values");

endmodule

bind line_sensor_p_steering lsps_checker u_lsps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_line_pattern  (o_line_pattern),
    .o_drive_update  (o_drive_update),
    .o_right_reverse (o_right_reverse),
    .o_right_forward (o_right_forward),
    .o_left_reverse  (o_left_reverse),
    .o_left_forward  (o_left_forward)
);

/* tb/line_sensor_p_steering_tb.sv */
// Self-checking testbench for the line sensor steering block: directed and random runs.
`timescale 1ns / 1ps

module line_sensor_p_steering_tb;
    import lsps_pkg::*;

    localparam int NCH          = 8;
    localparam int SMAX         = 4095;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_TAIL    = 20;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // modes five to seven are unassigned and behave as observe
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam logic [PAT_W-1:0]  PAT_PIVOT_LEFT  = 8'h01;
    localparam logic [PAT_W-1:0]  PAT_PIVOT_RIGHT = 8'h80;
    // pivots, centred run, blank, all dark, broken run
    localparam logic [PAT_W-1:0]  DIRECTED_PATS [6] =
        '{PAT_PIVOT_LEFT, PAT_PIVOT_RIGHT, 8'h18, 8'h00, 8'hFF, 8'hA5};

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic [NCH-1:0][SAMPLE_W-1:0] smp;
    } t_scan;

    typedef struct packed {
        logic [PAT_W-1:0]   pattern;
        logic               update;
        logic [SPEED_W-1:0] rr;
        logic [SPEED_W-1:0] rf;
        logic [SPEED_W-1:0] lr;
        logic [SPEED_W-1:0] lf;
    } t_drive_res;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    logic [MODE_W-1:0]            i_mode      = '0;
    logic [NCH-1:0][SAMPLE_W-1:0] i_smp       = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [PAT_W-1:0]             o_line_pattern;
    logic                         o_drive_update;
    logic [SPEED_W-1:0]           o_right_reverse;
    logic [SPEED_W-1:0]           o_right_forward;
    logic [SPEED_W-1:0]           o_left_reverse;
    logic [SPEED_W-1:0]           o_left_forward;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data  = '0;

    // predictor state
    logic [SAMPLE_W-1:0] thr_lvl [NCH];
    logic [SAMPLE_W-1:0] cal_max [NCH];
    logic [SAMPLE_W-1:0] cal_min [NCH];
    logic [PAT_W-1:0]    last_pat;
    logic [CONF_W-1:0]   confirm_left;
    logic [SPEED_W-1:0]  drv [4];
    logic [GAIN_W-1:0]   reg_gain;
    logic [SETP_W-1:0]   reg_setp;
    logic [SPEED_W-1:0]  reg_base;
    logic [SPEED_W-1:0]  reg_lo;
    logic [SPEED_W-1:0]  reg_hi;
    logic [CONF_W-1:0]   reg_confirm;
    logic [SPEED_W-1:0]  reg_fast;
    logic [SPEED_W-1:0]  reg_slow;

    t_drive_res pending_results [$];
    int n_mismatch  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    line_sensor_p_steering u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_sample_0      (i_smp[0]),
        .i_sample_1      (i_smp[1]),
        .i_sample_2      (i_smp[2]),
        .i_sample_3      (i_smp[3]),
        .i_sample_4      (i_smp[4]),
        .i_sample_5      (i_smp[5]),
        .i_sample_6      (i_smp[6]),
        .i_sample_7      (i_smp[7]),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_line_pattern  (o_line_pattern),
        .o_drive_update  (o_drive_update),
        .o_right_reverse (o_right_reverse),
        .o_right_forward (o_right_forward),
        .o_left_reverse  (o_left_reverse),
        .o_left_forward  (o_left_forward),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [SPEED_W-1:0] clamp_speed(int x);
        if (x < int'(reg_lo)) begin
            return reg_lo;
        end else if (x > int'(reg_hi)) begin
            return reg_hi;
        end
        return SPEED_W'(x);
    endfunction

    function automatic t_drive_res predict_steering(t_scan s);
        t_drive_res       r;
        logic [PAT_W-1:0] pat;
        logic [PAT_W:0]   carry;
        logic             upd;
        int               i, sum, ones, corr;
        pat = '0;
        upd = 1'b0;
        for (i = 0; i < NCH; i++) begin
            if (s.smp[i] > thr_lvl[i]) pat[NCH-1-i] = 1'b1;
        end
        case (s.mode)
            MODE_RUN: begin
                // adding the lowest set bit clears a single run completely
                carry = {1'b0, pat} + {1'b0, pat & (~pat + 1'b1)};
                if (pat != '0 && pat != '1 && pat == last_pat &&
                        ({1'b0, pat} & carry) == '0) begin
                    if (confirm_left == '0) begin
                        if (pat == PAT_PIVOT_LEFT) begin
                            drv = '{'0, reg_fast, reg_slow, '0};
                        end else if (pat == PAT_PIVOT_RIGHT) begin
                            drv = '{reg_slow, '0, '0, reg_fast};
                        end else begin
                            sum  = 0;
                            ones = 0;
                            for (i = 0; i < PAT_W; i++) begin
                                if (pat[i]) begin
                                    sum += 2 * i;
                                    ones++;
                                end
                            end
                            corr = int'(reg_gain) * (sum / ones - int'(reg_setp));
                            drv = '{'0, clamp_speed(int'(reg_base) - corr),
                                    '0, clamp_speed(int'(reg_base) + corr)};
                        end
                        upd = 1'b1;
                        confirm_left = reg_confirm;
                    end else begin
                        confirm_left = confirm_left - 1'b1;
                    end
                end else begin
                    last_pat     = pat;
                    confirm_left = reg_confirm;
                end
            end
            MODE_CAL_SAMPLE: begin
                for (i = 0; i < NCH; i++) begin
                    if (s.smp[i] > cal_max[i]) cal_max[i] = s.smp[i];
                    if (s.smp[i] < cal_min[i]) cal_min[i] = s.smp[i];
                end
            end
            MODE_CAL_FINISH: begin
                // signed difference, halving truncates toward zero
                for (i = 0; i < NCH; i++) begin
                    thr_lvl[i] = SAMPLE_W'(int'(cal_min[i]) +
                                           (int'(cal_max[i]) - int'(cal_min[i])) / 2);
                    cal_max[i] = '0;
                    cal_min[i] = SAMPLE_W'(SMAX);
                end
                drv = '{'0, '0, '0, '0};
                upd = 1'b1;
            end
            MODE_LOAD_THR: begin
                for (i = 0; i < NCH; i++) thr_lvl[i] = s.smp[i];
            end
            default: ;
        endcase
        r.pattern = pat;
        r.update  = upd;
        r.rr      = drv[0];
        r.rf      = drv[1];
        r.lr      = drv[2];
        r.lf      = drv[3];
        return r;
    endfunction

    function automatic t_scan random_scan(logic [MODE_W-1:0] mode);
        t_scan s;
        int    i;
        s.mode = mode;
        for (i = 0; i < NCH; i++) s.smp[i] = SAMPLE_W'($urandom_range(SMAX, 0));
        return s;
    endfunction

    // samples placed either side of the current thresholds to give the wanted pattern
    function automatic t_scan scan_for_pattern(logic [MODE_W-1:0] mode, logic [PAT_W-1:0] pat);
        t_scan s;
        int    i, t;
        s.mode = mode;
        for (i = 0; i < NCH; i++) begin
            t = int'(thr_lvl[i]);
            if (pat[NCH-1-i]) begin
                s.smp[i] = (t >= SMAX) ? SAMPLE_W'(SMAX) : SAMPLE_W'($urandom_range(SMAX, t + 1));
            end else begin
                s.smp[i] = SAMPLE_W'($urandom_range(t, 0));
            end
        end
        return s;
    endfunction

    function automatic logic [PAT_W-1:0] random_run_pattern();
        int len, lo;
        if ($urandom_range(99) < 15) begin
            return ($urandom_range(1) == 1) ? PAT_PIVOT_LEFT : PAT_PIVOT_RIGHT;
        end
        len = $urandom_range(PAT_W - 1, 1);
        lo  = $urandom_range(PAT_W - len, 0);
        return PAT_W'(((1 << len) - 1) << lo);
    endfunction

    task automatic send_scan(t_scan s);
        @(negedge i_clk);
        // each cycle the sender idles with the set chance before offering
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_mode     <= s.mode;
        i_smp      <= s.smp;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_steering(s));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_TAIL) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN:          reg_gain    = GAIN_W'(value);
            CFG_SETPOINT:      reg_setp    = SETP_W'(value);
            CFG_BASE_SPEED:    reg_base    = SPEED_W'(value);
            CFG_SPEED_LO:      reg_lo      = SPEED_W'(value);
            CFG_SPEED_HI:      reg_hi      = SPEED_W'(value);
            CFG_CONFIRM_COUNT: reg_confirm = CONF_W'(value);
            CFG_TURN_FAST:     reg_fast    = SPEED_W'(value);
            CFG_TURN_SLOW:     reg_slow    = SPEED_W'(value);
            default: ;
        endcase
    endtask

    task automatic write_settings(int gain, int setp, int base, int lo, int hi, int conf,
                                  int fast, int slow);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_SETPOINT, setp);
        write_reg(CFG_BASE_SPEED, base);
        write_reg(CFG_SPEED_LO, lo);
        write_reg(CFG_SPEED_HI, hi);
        write_reg(CFG_CONFIRM_COUNT, conf);
        write_reg(CFG_TURN_FAST, fast);
        write_reg(CFG_TURN_SLOW, slow);
    endtask

    task automatic random_block(int n);
        t_scan            s;
        logic [PAT_W-1:0] pat;
        int               done_n, k, r, i;
        done_n = 0;
        while (done_n < n) begin
            r = $urandom_range(99);
            if (r < 60) begin
                // a run of identical readings of random length, which may or may not get past the countdown
                pat = random_run_pattern();
                k   = $urandom_range(int'(reg_confirm) + 3, 1);
                repeat (k) send_scan(scan_for_pattern(MODE_RUN, pat));
                done_n += k;
            end else if (r < 70) begin
                k = $urandom_range(4, 1);
                repeat (k) send_scan(random_scan(MODE_CAL_SAMPLE));
                send_scan(random_scan(MODE_CAL_FINISH));
                done_n += k + 1;
            end else if (r < 78) begin
                s = random_scan(MODE_LOAD_THR);
                if (r >= 72) begin
                    for (i = 0; i < NCH; i++) s.smp[i] = SAMPLE_W'($urandom_range(3840, 256));
                end
                send_scan(s);
                done_n++;
            end else begin
                send_scan(random_scan(MODE_W'($urandom_range(7, 0))));
                done_n++;
            end
        end
    endtask

    task automatic test_directed();
        t_scan s;
        int    i;
        write_reg(CFG_CONFIRM_COUNT, 0);
        s.mode = MODE_OBSERVE;
        s.smp  = '0;
        send_scan(s);
        s.smp = '1;
        send_scan(s);
        s.mode = MODE_LOAD_THR;
        s.smp  = '0;
        send_scan(s);
        s.mode = MODE_OBSERVE;
        s.smp  = '1;
        send_scan(s);
        s.mode = MODE_LOAD_THR;
        send_scan(s);
        s.mode = MODE_OBSERVE;
        send_scan(s);
        s.mode = MODE_LOAD_THR;
        for (i = 0; i < NCH; i++) s.smp[i] = SAMPLE_W'(THR_RESET);
        send_scan(s);
        foreach (DIRECTED_PATS[p]) begin
            repeat (2) send_scan(scan_for_pattern(MODE_RUN, DIRECTED_PATS[p]));
        end
        send_scan(random_scan(MODE_CAL_SAMPLE));
        send_scan(random_scan(MODE_CAL_SAMPLE));
        send_scan(random_scan(MODE_CAL_FINISH));
        // finish with no samples taken falls back to mid-scale
        send_scan(random_scan(MODE_CAL_FINISH));
        send_scan(random_scan(MODE_SPARE_LO));
        send_scan(random_scan(MODE_SPARE_HI));
        wait_idle();
    endtask

    task automatic test_full_queue();
        logic [PAT_W-1:0] pat;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pat = random_run_pattern();
        @(posedge i_clk);
        hold_req++;
        repeat (24) send_scan(scan_for_pattern(MODE_RUN, pat));
        wait_idle();
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct);
        int blk;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (blk = 0; blk < 5; blk++) begin
            case (blk)
                0, 3: write_settings($urandom_range(255, 0), $urandom_range(14, 0),
                                     $urandom_range(2047, 0), $urandom_range(1000, 0),
                                     $urandom_range(2047, 800), $urandom_range(4, 0),
                                     $urandom_range(2047, 0), $urandom_range(2047, 0));
                1: write_settings(255, 0, 2047, 0, 2047, 0, 2047, 0);
                // lower clamp above upper clamp: the lower clamp wins
                2: write_settings(0, 14, 0, 2047, 0, 15, 0, 2047);
                default: write_settings(255, 14, 1024, 0, 2047, 1, 2047, 2047);
            endcase
            random_block(100);
            wait_idle();
        end
    endtask

    // receiver stall; a hold request forces a long stretch of back-pressure
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            n_mismatch++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_drive_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual pattern %0d",
                         $time, o_line_pattern);
                n_mismatch++;
            end else begin
                want = pending_results.pop_front();
                check_field("line_pattern", int'(want.pattern), int'(o_line_pattern));
                check_field("drive_update", int'(want.update), int'(o_drive_update));
                check_field("right_reverse", int'(want.rr), int'(o_right_reverse));
                check_field("right_forward", int'(want.rf), int'(o_right_forward));
                check_field("left_reverse", int'(want.lr), int'(o_left_reverse));
                check_field("left_forward", int'(want.lf), int'(o_left_forward));
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        for (int i = 0; i < NCH; i++) begin
            thr_lvl[i] = SAMPLE_W'(THR_RESET);
            cal_max[i] = '0;
            cal_min[i] = SAMPLE_W'(SMAX);
        end
        last_pat     = '0;
        confirm_left = CONFIRM_RESET;
        drv          = '{'0, '0, '0, '0};
        reg_gain     = GAIN_RESET;
        reg_setp     = SETPOINT_RESET;
        reg_base     = BASE_SPEED_RESET;
        reg_lo       = SPEED_LO_RESET;
        reg_hi       = SPEED_HI_RESET;
        reg_confirm  = CONFIRM_RESET;
        reg_fast     = TURN_FAST_RESET;
        reg_slow     = TURN_SLOW_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_queue();
        test_random_traffic(13, 58);
        test_random_traffic(58, 13);
        test_random_traffic(0, 0);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lsps_pkg.sv
hw/rtl/lsps_front.sv
hw/rtl/lsps_queue.sv
hw/rtl/lsps_back.sv
hw/rtl/line_sensor_p_steering.sv
hw/rtl/lsps_checker.sv
tb/line_sensor_p_steering_tb.sv
